### hw/rtl/rme_pkg.sv
// Package with the shared types, constants and helper functions of the Euler angle block.
`timescale 1ns / 1ps
package rme_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ANGLE_BITS   = 16;
  localparam int TABLE_LEN    = 24;
  localparam int CORDIC_ITERS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

  localparam int ELEM_W  = 16;
  localparam int OP_W    = ELEM_W + 1;
  localparam int CW      = OP_W + 16 + 3;
  localparam int THR_W   = 15;
  localparam int OUT_W   = 16;

  localparam int RAD_W       = 32;
  localparam int SQRT_STEPS  = RAD_W / 2;
  localparam int REM_W       = SQRT_STEPS + 3;

  // Input register, product stage, sum stage, square root, selection, CORDIC, output register.
  localparam int PIPE_DEPTH = 6 + SQRT_STEPS + CORDIC_ITERS;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

  localparam logic [31:0] ATAN_TAB [0:TABLE_LEN-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic signed [ELEM_W-1:0] m00;
    logic signed [ELEM_W-1:0] m10;
    logic signed [ELEM_W-1:0] m20;
    logic signed [ELEM_W-1:0] m21;
    logic signed [ELEM_W-1:0] m22;
    logic signed [ELEM_W-1:0] m11;
    logic signed [ELEM_W-1:0] m12;
  } mat_t;

  typedef struct packed {
    logic [OUT_W-1:0] angle_x;
    logic [OUT_W-1:0] angle_y;
    logic [OUT_W-1:0] angle_z;
    logic             singular;
  } ang_t;

  // Rotation of step i, rounded half up to the accumulator width.
  function automatic logic [ANGLE_BITS-1:0] step_angle(input int i);
    logic [32:0] sum;
    sum = {1'b0, ATAN_TAB[i]} + (33'(1) << (31 - ANGLE_BITS));
    return ANGLE_BITS'(sum >> (32 - ANGLE_BITS));
  endfunction

  // Brings an accumulator angle to the 16-bit output scale.
  function automatic logic [OUT_W-1:0] to_out16(input logic [ANGLE_BITS-1:0] a);
    logic [ANGLE_BITS:0] t;
    logic [31:0]         w;
    t = '0;
    w = '0;
    if (ANGLE_BITS > OUT_W) begin
      t = {1'b0, a} + ((ANGLE_BITS+1)'(1) << ((ANGLE_BITS > OUT_W) ? ANGLE_BITS - 17 : 0));
      return OUT_W'(t >> ((ANGLE_BITS > OUT_W) ? ANGLE_BITS - OUT_W : 0));
    end else begin
      w = 32'(a) << ((ANGLE_BITS < OUT_W) ? OUT_W - ANGLE_BITS : 0);
      return OUT_W'(w);
    end
  endfunction

endpackage

### hw/rtl/rme_if.sv
// Valid/ready stream interfaces for the matrix input, angle output and threshold write.
`timescale 1ns / 1ps
interface rme_in_if;
  logic          valid;
  logic          ready;
  rme_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rme_out_if;
  logic          valid;
  logic          ready;
  rme_pkg::ang_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface rme_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [rme_pkg::THR_W-1:0]   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/rme_sqrt.sv
// Pipelined integer square root, one result bit per register stage.
`timescale 1ns / 1ps
module rme_sqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic [rme_pkg::RAD_W-1:0]         n,
  output logic [rme_pkg::SQRT_STEPS-1:0]    root
);

  localparam int S = rme_pkg::SQRT_STEPS;

  logic [rme_pkg::REM_W-1:0] rem  [0:S-1];
  logic [S-1:0]              rt   [0:S-1];
  logic [rme_pkg::RAD_W-1:0] rad  [0:S-1];

  logic [rme_pkg::REM_W-1:0] rem_next [0:S-1];
  logic [S-1:0]              rt_next  [0:S-1];
  logic [rme_pkg::RAD_W-1:0] rad_next [0:S-1];

  genvar k;
  generate
    for (k = 0; k < S; k++) begin : g_step
      logic [rme_pkg::REM_W-1:0] rem_in;
      logic [S-1:0]              rt_in;
      logic [rme_pkg::RAD_W-1:0] rad_in;
      logic [rme_pkg::REM_W-1:0] rem_sh;
      logic [rme_pkg::REM_W-1:0] trial;
      logic                      ge;

      if (k == 0) begin : g_first
        assign rem_in = '0;
        assign rt_in  = '0;
        assign rad_in = n;
      end else begin : g_rest
        assign rem_in = rem[k-1];
        assign rt_in  = rt[k-1];
        assign rad_in = rad[k-1];
      end

      // Bring down two radicand bits and try the next root bit.
      assign rem_sh = {rem_in[rme_pkg::REM_W-3:0], rad_in[rme_pkg::RAD_W-1 -: 2]};
      assign trial  = rme_pkg::REM_W'({rt_in, 2'b01});
      assign ge     = rem_sh >= trial;

      assign rem_next[k] = ge ? rem_sh - trial : rem_sh;
      assign rt_next[k]  = {rt_in[S-2:0], ge};
      assign rad_next[k] = rad_in << 2;

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rem_next[k];
          rt[k]  <= rt_next[k];
          rad[k] <= rad_next[k];
        end
      end
    end
  endgenerate

  assign root = rt[S-1];

endmodule

### hw/rtl/rme_cordic.sv
// Pipelined vectoring CORDIC that returns the angle of a vector as a fraction of a turn.
`timescale 1ns / 1ps
module rme_cordic (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [rme_pkg::OP_W-1:0]       y_in,
  input  logic signed [rme_pkg::OP_W-1:0]       x_in,
  output logic [rme_pkg::ANGLE_BITS-1:0]        angle
);

  localparam int N  = rme_pkg::CORDIC_ITERS;
  localparam int CW = rme_pkg::CW;
  localparam int AB = rme_pkg::ANGLE_BITS;
  localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

  logic signed [CW-1:0] x    [0:N];
  logic signed [CW-1:0] y    [0:N];
  logic [AB-1:0]        acc  [0:N];
  logic                 zero [0:N];

  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [CW-1:0] x0_next;
  logic signed [CW-1:0] y0_next;
  logic [AB-1:0]        acc0_next;

  assign xs = CW'(x_in) <<< 16;
  assign ys = CW'(y_in) <<< 16;

  // A vector in the left half-plane is turned by a quarter turn first.
  always_comb begin
    x0_next   = xs;
    y0_next   = ys;
    acc0_next = '0;
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0_next   = ys;
        y0_next   = -xs;
        acc0_next = QUARTER;
      end else begin
        x0_next   = -ys;
        y0_next   = xs;
        acc0_next = -QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0]    <= x0_next;
      y[0]    <= y0_next;
      acc[0]  <= acc0_next;
      zero[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  genvar i;
  generate
    for (i = 0; i < N; i++) begin : g_iter
      logic signed [CW-1:0] dx;
      logic signed [CW-1:0] dy;
      logic [AB-1:0]        da;
      assign dx = y[i] >>> i;
      assign dy = x[i] >>> i;
      assign da = rme_pkg::step_angle(i);

      always_ff @(posedge clk) begin
        if (en) begin
          if (y[i] >= 0) begin
            x[i+1]   <= x[i] + dx;
            y[i+1]   <= y[i] - dy;
            acc[i+1] <= acc[i] + da;
          end else begin
            x[i+1]   <= x[i] - dx;
            y[i+1]   <= y[i] + dy;
            acc[i+1] <= acc[i] - da;
          end
          zero[i+1] <= zero[i];
        end
      end
    end
  endgenerate

  assign angle = zero[N] ? '0 : acc[N];

endmodule

### hw/rtl/rotation_matrix_to_euler_top.sv
// Top level of the rotation matrix to XYZ Euler angle converter.
`timescale 1ns / 1ps
// The block takes one matrix per clock cycle while the output is not stalled, and delivers
// one set of angles per matrix, in order. A matrix passes through the input register, the
// squares and their sum, the one-bit-per-stage square root, a stage that picks the singular
// or regular operands, the three CORDIC pipelines that run side by side, and the output
// register. The whole pipeline moves as one and halts while a finished result waits, so a
// stall loses nothing. The threshold register takes its write at once and should only be
// written while no matrix is in flight.
module rotation_matrix_to_euler_top (
  input  logic      clk,
  input  logic      rst,
  rme_in_if.sink    mat_in,
  rme_out_if.source ang_out,
  rme_cfg_if.sink   cfg
);

  localparam int D = rme_pkg::PIPE_DEPTH;
  localparam int S = rme_pkg::SQRT_STEPS;
  localparam int N = rme_pkg::CORDIC_ITERS;

  logic                         adv;
  logic [D-1:0]                 vld;
  logic [rme_pkg::THR_W-1:0]    thr;

  rme_pkg::mat_t                mat_s0;
  rme_pkg::mat_t                mat_s1;
  rme_pkg::mat_t                mat_s2;
  rme_pkg::mat_t                mat_d [0:S-1];
  logic [rme_pkg::RAD_W-1:0]    sq00;
  logic [rme_pkg::RAD_W-1:0]    sq10;
  logic [rme_pkg::RAD_W-1:0]    sumsq;
  logic [S-1:0]                 root;

  logic signed [rme_pkg::OP_W-1:0] xa_y, xa_x, ya_y, ya_x, za_y, za_x;
  logic                         sing;
  logic                         sing_d [0:N];
  logic [rme_pkg::ANGLE_BITS-1:0] ang_x, ang_y, ang_z;
  rme_pkg::ang_t                res;

  assign adv          = ang_out.ready | ~vld[D-1];
  assign mat_in.ready = adv;
  assign cfg.ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= rme_pkg::THR_RESET;
    end else if (cfg.valid) begin
      thr <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[D-2:0], mat_in.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mat_s0 <= mat_in.data;
      mat_s1 <= mat_s0;
      sq00   <= rme_pkg::RAD_W'(mat_s0.m00 * mat_s0.m00);
      sq10   <= rme_pkg::RAD_W'(mat_s0.m10 * mat_s0.m10);
      mat_s2 <= mat_s1;
      sumsq  <= sq00 + sq10;
      mat_d[0] <= mat_s2;
      for (int k = 1; k < S; k++) begin
        mat_d[k] <= mat_d[k-1];
      end
    end
  end

  rme_sqrt u_sqrt (
    .clk  (clk),
    .en   (adv),
    .n    (sumsq),
    .root (root)
  );

  // Square root and matrix meet here; the threshold picks the operands for x.
  always_ff @(posedge clk) begin
    if (adv) begin
      sing <= root < S'(thr);
      if (root < S'(thr)) begin
        xa_y <= -rme_pkg::OP_W'(mat_d[S-1].m12);
        xa_x <= rme_pkg::OP_W'(mat_d[S-1].m11);
      end else begin
        xa_y <= rme_pkg::OP_W'(mat_d[S-1].m21);
        xa_x <= rme_pkg::OP_W'(mat_d[S-1].m22);
      end
      ya_y <= -rme_pkg::OP_W'(mat_d[S-1].m20);
      ya_x <= $signed({1'b0, root});
      za_y <= rme_pkg::OP_W'(mat_d[S-1].m10);
      za_x <= rme_pkg::OP_W'(mat_d[S-1].m00);
      sing_d[0] <= sing;
      for (int k = 1; k <= N; k++) begin
        sing_d[k] <= sing_d[k-1];
      end
    end
  end

  rme_cordic u_cordic_x (.clk(clk), .en(adv), .y_in(xa_y), .x_in(xa_x), .angle(ang_x));
  rme_cordic u_cordic_y (.clk(clk), .en(adv), .y_in(ya_y), .x_in(ya_x), .angle(ang_y));
  rme_cordic u_cordic_z (.clk(clk), .en(adv), .y_in(za_y), .x_in(za_x), .angle(ang_z));

  always_ff @(posedge clk) begin
    if (adv) begin
      res.angle_x  <= rme_pkg::to_out16(ang_x);
      res.angle_y  <= rme_pkg::to_out16(ang_y);
      res.angle_z  <= sing_d[N] ? '0 : rme_pkg::to_out16(ang_z);
      res.singular <= sing_d[N];
    end
  end

  assign ang_out.valid = vld[D-1];
  assign ang_out.data  = res;

endmodule
